FILE: rtl/core/pftm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pftm_pkg
// Shared types and constants of the player frame receiver and track mapper.
// ---------------------------------------------------------------------------
package pftm_pkg;

   // Frame layout.
   localparam logic [7:0] START_BYTE   = 8'h7E;
   localparam logic [7:0] END_BYTE     = 8'hEF;
   localparam logic [3:0] LAST_POS     = 4'd9;
   localparam logic [3:0] CMD_POS      = 4'd3;
   localparam logic [3:0] PARAM_HI_POS = 4'd5;
   localparam logic [3:0] PARAM_LO_POS = 4'd6;

   // Command codes.
   localparam logic [7:0] CMD_FINISH_A = 8'h3C;
   localparam logic [7:0] CMD_FINISH_B = 8'h3D;
   localparam logic [7:0] CMD_FINISH_C = 8'h3E;
   localparam logic [7:0] CMD_CURRENT  = 8'h4C;
   localparam logic [7:0] CMD_TOTAL    = 8'h48;

   // Event codes.
   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_FINISHED = 2'd1;
   localparam logic [1:0] EV_CURRENT  = 2'd2;
   localparam logic [1:0] EV_TOTAL    = 2'd3;

   // Register indexes.
   localparam logic CSR_FIXED_COUNT = 1'b0;
   localparam logic CSR_OFFSET      = 1'b1;

   localparam int TRACK_W = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MOD_TRACK,
      ST_MOD_OFFSET,
      ST_DONE
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic take_byte;
      logic div_start;
      logic div_sel_offset;
      logic save_track_rem;
      logic save_offset_rem;
      logic commit;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic upd_track;
      logic count_zero;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

FILE: rtl/core/player_frame_receiver_track_map_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// player_frame_receiver_track_map_core
// Parses fixed-length player link frames and keeps module and logical track.
//
//   Channel  Ports                          Direction  Moves
//   req      req_valid / req_stall          in         one received byte
//   rsp      rsp_valid / rsp_stall          out        event and track status
//   csr      csr_wr_en / csr_index          in         track count, offset
//
// Each byte is one transaction and yields exactly one result transaction.
// A byte passes intake, decode and commit; a track report that is mapped
// over a nonzero count adds two runs of the shared remainder unit.
// Reset is synchronous and clears the parser, track state and result flag.
// A stalled result holds in the output register; the next byte is still
// taken and processed, and waits only for its own commit.
// ---------------------------------------------------------------------------
module player_frame_receiver_track_map_core
   import pftm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_code,
   output logic [15:0] rsp_logical_track,
   output logic [15:0] rsp_module_track,
   output logic        rsp_track_known,
   output logic [15:0] rsp_total_tracks,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   pftm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // Datapath.
   pftm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_code    (rsp_event_code),
      .rsp_logical_track (rsp_logical_track),
      .rsp_module_track  (rsp_module_track),
      .rsp_track_known   (rsp_track_known),
      .rsp_total_tracks  (rsp_total_tracks)
   );

endmodule

FILE: rtl/core/pftm_mod_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pftm_mod_unit
// Restoring remainder unit: one quotient bit per cycle over all TRACK_W dividend bits.
// ---------------------------------------------------------------------------
module pftm_mod_unit
   import pftm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TRACK_W-1:0]   dividend,
   input  logic [TRACK_W-1:0]   divisor,
   output logic                 done,
   output logic [TRACK_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(TRACK_W + 1);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TRACK_W-1:0] rem_ff, rem_in;
   logic [TRACK_W-1:0] dvd_ff, dvd_in;
   logic [TRACK_W-1:0] div_ff, div_in;
   logic [TRACK_W:0]   trial;

   assign done      = busy_ff && (cnt_ff == '0);
   assign remainder = rem_ff;

   // One shift and conditional subtract per cycle.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      trial   = {rem_ff, dvd_ff[TRACK_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(TRACK_W);
         rem_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            if (trial >= {1'b0, div_ff}) begin
               trial = trial - {1'b0, div_ff};
            end
            rem_in = trial[TRACK_W-1:0];
            dvd_in = {dvd_ff[TRACK_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

endmodule

FILE: rtl/core/pftm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pftm_ctrl
// Sequencer: byte intake, track remainder runs, commit and result hand-off.
// ---------------------------------------------------------------------------
module pftm_ctrl
   import pftm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take_byte = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.upd_track && !status.count_zero) begin
               cmd.div_start = 1'b1;
               state_in      = ST_MOD_TRACK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MOD_TRACK: begin
            if (status.div_done) begin
               cmd.save_track_rem = 1'b1;
               cmd.div_start      = 1'b1;
               cmd.div_sel_offset = 1'b1;
               state_in           = ST_MOD_OFFSET;
            end
         end
         ST_MOD_OFFSET: begin
            if (status.div_done) begin
               cmd.save_offset_rem = 1'b1;
               state_in            = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/pftm_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pftm_datapath
// Frame capture, command decode, track registers, mapping and result register.
// ---------------------------------------------------------------------------
module pftm_datapath
   import pftm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_event_code,
   output logic [15:0]        rsp_logical_track,
   output logic [15:0]        rsp_module_track,
   output logic               rsp_track_known,
   output logic [15:0]        rsp_total_tracks
);

   // Configuration registers.
   logic [TRACK_W-1:0] fixed_count_ff, offset_ff;

   // Frame parser state.
   logic [3:0]         pos_ff, pos_in;
   logic [7:0]         cmd_byte_ff;
   logic [7:0]         param_hi_ff;
   logic [7:0]         param_lo_ff;

   // Decoded transaction.
   logic [1:0]         ev_ff, ev_in;
   logic               upd_ff, upd_in;
   logic               known_wr_ff, known_wr_in;
   logic               known_val_ff, known_val_in;
   logic               total_wr_ff, total_wr_in;
   logic [TRACK_W-1:0] param_ff;

   // Tracking state.
   logic [TRACK_W-1:0] total_ff, module_ff, logical_ff;
   logic               known_ff;

   // Remainders and result register.
   logic [TRACK_W-1:0] track_rem_ff, offset_rem_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_ev_ff;
   logic [TRACK_W-1:0] rsp_logical_ff, rsp_module_ff, rsp_total_ff;
   logic               rsp_known_ff;

   logic [TRACK_W-1:0] param_now;
   logic [TRACK_W-1:0] count;
   logic [TRACK_W-1:0] div_dividend, div_rem;
   logic               div_done;
   logic [TRACK_W:0]   wrap_sum;
   logic [TRACK_W-1:0] mapped;
   logic [TRACK_W-1:0] logical_next, module_next, total_next;
   logic               known_next;

   assign param_now = {param_hi_ff, param_lo_ff};
   assign count     = (fixed_count_ff != '0) ? fixed_count_ff : total_ff;

   // Byte position update and frame decode on the closing byte.
   always_comb begin
      pos_in       = pos_ff;
      ev_in        = EV_NONE;
      upd_in       = 1'b0;
      known_wr_in  = 1'b0;
      known_val_in = 1'b0;
      total_wr_in  = 1'b0;
      if (!(pos_ff == '0 && req_rx_byte != START_BYTE)) begin
         if (pos_ff < LAST_POS) begin
            pos_in = pos_ff + 1'b1;
         end else begin
            pos_in = '0;
            if (req_rx_byte == END_BYTE) begin
               unique case (cmd_byte_ff)
                  CMD_FINISH_A, CMD_FINISH_B, CMD_FINISH_C: begin
                     ev_in        = EV_FINISHED;
                     upd_in       = (param_now != '0);
                     known_wr_in  = 1'b1;
                     known_val_in = (param_now != '0);
                  end
                  CMD_CURRENT: begin
                     ev_in        = EV_CURRENT;
                     upd_in       = (param_now != '0);
                     known_wr_in  = (param_now != '0);
                     known_val_in = 1'b1;
                  end
                  CMD_TOTAL: begin
                     ev_in       = EV_TOTAL;
                     total_wr_in = 1'b1;
                  end
                  default: begin
                     ev_in = EV_NONE;
                  end
               endcase
            end
         end
      end
   end

   // Shared remainder unit: first the track minus one, then the offset.
   assign div_dividend = cmd.div_sel_offset ? offset_ff : (param_ff - 1'b1);

   pftm_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (count),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Mapping and next tracking values for the commit.
   always_comb begin
      wrap_sum = {1'b0, track_rem_ff} + {1'b0, count - offset_rem_ff};
      if (wrap_sum >= {1'b0, count}) begin
         wrap_sum = wrap_sum - {1'b0, count};
      end
      if (count == '0) begin
         mapped = (param_ff > offset_ff) ? (param_ff - offset_ff) : param_ff;
      end else begin
         mapped = wrap_sum[TRACK_W-1:0] + 1'b1;
      end
      module_next  = upd_ff ? param_ff : module_ff;
      logical_next = upd_ff ? mapped : logical_ff;
      known_next   = known_wr_ff ? known_val_ff : known_ff;
      total_next   = total_wr_ff ? param_ff : total_ff;
   end

   assign status.upd_track  = upd_ff;
   assign status.count_zero = (count == '0);
   assign status.div_done   = div_done;
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_count_ff <= '0;
         offset_ff      <= '0;
         pos_ff         <= '0;
         total_ff       <= '0;
         module_ff      <= '0;
         logical_ff     <= '0;
         known_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FIXED_COUNT: fixed_count_ff <= csr_wdata;
               CSR_OFFSET:      offset_ff      <= csr_wdata;
               default:         fixed_count_ff <= fixed_count_ff;
            endcase
         end
         if (cmd.take_byte) begin
            pos_ff <= pos_in;
         end
         if (cmd.commit) begin
            total_ff   <= total_next;
            module_ff  <= module_next;
            logical_ff <= logical_next;
            known_ff   <= known_next;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         if (pos_ff == CMD_POS) begin
            cmd_byte_ff <= req_rx_byte;
         end
         if (pos_ff == PARAM_HI_POS) begin
            param_hi_ff <= req_rx_byte;
         end
         if (pos_ff == PARAM_LO_POS) begin
            param_lo_ff <= req_rx_byte;
         end
         ev_ff        <= ev_in;
         upd_ff       <= upd_in;
         known_wr_ff  <= known_wr_in;
         known_val_ff <= known_val_in;
         total_wr_ff  <= total_wr_in;
         param_ff     <= param_now;
      end
      if (cmd.save_track_rem) begin
         track_rem_ff <= div_rem;
      end
      if (cmd.save_offset_rem) begin
         offset_rem_ff <= div_rem;
      end
      if (cmd.commit) begin
         rsp_ev_ff      <= ev_ff;
         rsp_logical_ff <= logical_next;
         rsp_module_ff  <= module_next;
         rsp_known_ff   <= known_next;
         rsp_total_ff   <= total_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_code    = rsp_ev_ff;
   assign rsp_logical_track = rsp_logical_ff;
   assign rsp_module_track  = rsp_module_ff;
   assign rsp_track_known   = rsp_known_ff;
   assign rsp_total_tracks  = rsp_total_ff;

endmodule
